// File: sv/thumb_to_arm_decompressor_defines.svh
// Assertion macros used by the decompressor top module.
`ifndef THUMB_TO_ARM_DECOMPRESSOR_DEFINES_SVH
`define THUMB_TO_ARM_DECOMPRESSOR_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent this cycle implies consequent in the next cycle.
`define T2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("t2a: next-cycle check failed");

// Antecedent implies consequent in the same cycle.
`define T2A_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("t2a: same-cycle check failed");

`else

`define T2A_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define T2A_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/t2a_pkg.sv
package t2a_pkg;

	// handler classes
	localparam logic [3:0] CL_DP    = 4'd0;
	localparam logic [3:0] CL_DPIMM = 4'd1;
	localparam logic [3:0] CL_MUL   = 4'd2;
	localparam logic [3:0] CL_SDT   = 4'd3;
	localparam logic [3:0] CL_BDT   = 4'd4;
	localparam logic [3:0] CL_BRA   = 4'd5;
	localparam logic [3:0] CL_UND   = 4'd6;
	localparam logic [3:0] CL_LONG  = 4'd7;
	localparam logic [3:0] CL_NONE  = 4'd8;

	// ARM data-processing opcodes
	localparam logic [3:0] OP_AND = 4'd0;
	localparam logic [3:0] OP_EOR = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_RSB = 4'd3;
	localparam logic [3:0] OP_ADD = 4'd4;
	localparam logic [3:0] OP_ADC = 4'd5;
	localparam logic [3:0] OP_SBC = 4'd6;
	localparam logic [3:0] OP_TST = 4'd8;
	localparam logic [3:0] OP_CMP = 4'd10;
	localparam logic [3:0] OP_ORR = 4'd12;
	localparam logic [3:0] OP_MOV = 4'd13;
	localparam logic [3:0] OP_BIC = 4'd14;
	localparam logic [3:0] OP_MVN = 4'd15;

	localparam logic [3:0] COND_AL = 4'hE;
	localparam logic [3:0] REG_SP  = 4'd13;
	localparam logic [3:0] REG_PC  = 4'd15;

	typedef struct packed {
		logic [31:0] arm_word;
		logic [3:0]  handler_class;
	} t2a_result_t;

endpackage

// File: sv/t2a_decode.sv
module t2a_decode import t2a_pkg::*; (
	input  logic [15:0] thumb_word,
	output t2a_result_t result
);

	logic [2:0]  r0, r1, r2, r8;
	logic [4:0]  im5;
	logic [7:0]  im8;
	logic [3:0]  hd, hm;
	logic [31:0] w;
	logic [3:0]  cl;

	assign r0  = thumb_word[2:0];
	assign r1  = thumb_word[5:3];
	assign r2  = thumb_word[8:6];
	assign r8  = thumb_word[10:8];
	assign im5 = thumb_word[10:6];
	assign im8 = thumb_word[7:0];
	// hi-register numbers: flag bits add 8
	assign hd  = {thumb_word[7], 1'b0, thumb_word[1:0]};
	assign hm  = {thumb_word[6], 1'b0, thumb_word[4:3]};

	always_comb begin
		w  = '0;
		cl = CL_NONE;
		unique casez (thumb_word[15:10])
			6'b0000??, 6'b00010?: begin
				// MOVS with immediate shift
				w[31:28] = COND_AL;
				w[24:21] = OP_MOV;
				w[20]    = 1'b1;
				w[14:12] = r0;
				w[11:7]  = im5;
				w[6:5]   = thumb_word[12:11];
				w[2:0]   = r1;
				cl       = CL_DP;
			end
			6'b000110: begin
				w[31:28] = COND_AL;
				w[24:21] = thumb_word[9] ? OP_SUB : OP_ADD;
				w[20]    = 1'b1;
				w[18:16] = r1;
				w[14:12] = r0;
				w[2:0]   = r2;
				cl       = CL_DP;
			end
			6'b00100?: begin
				w[31:28] = COND_AL;
				w[25]    = 1'b1;
				w[24:21] = OP_CMP;
				w[20]    = 1'b1;
				w[18:16] = r8;
				w[7:0]   = im8;
				cl       = CL_DPIMM;
			end
			6'b00101?: begin
				w[31:28] = COND_AL;
				w[25]    = 1'b1;
				w[24:21] = OP_MOV;
				w[20]    = 1'b1;
				w[14:12] = r8;
				w[7:0]   = im8;
				cl       = CL_DPIMM;
			end
			6'b0011??: begin
				w[31:28] = COND_AL;
				w[25]    = 1'b1;
				w[24:21] = thumb_word[11] ? OP_SUB : OP_ADD;
				w[20]    = 1'b1;
				w[18:16] = r8;
				w[14:12] = r8;
				w[7:0]   = im8;
				cl       = CL_DPIMM;
			end
			6'b010000: begin
				// two-address ALU group
				w[31:28] = COND_AL;
				w[20]    = 1'b1;
				cl       = CL_DP;
				unique case (thumb_word[9:6])
					4'd0, 4'd1, 4'd5, 4'd6, 4'd12, 4'd14: begin
						unique case (thumb_word[9:6])
							4'd0:    w[24:21] = OP_AND;
							4'd1:    w[24:21] = OP_EOR;
							4'd5:    w[24:21] = OP_ADC;
							4'd6:    w[24:21] = OP_SBC;
							4'd12:   w[24:21] = OP_ORR;
							default: w[24:21] = OP_BIC;
						endcase
						w[18:16] = r0;
						w[14:12] = r0;
						w[2:0]   = r1;
					end
					4'd2, 4'd3, 4'd4, 4'd7: begin
						// register-specified shift
						w[24:21] = OP_MOV;
						w[18:16] = r0;
						w[14:12] = r0;
						w[10:8]  = r1;
						w[4]     = 1'b1;
						unique case (thumb_word[9:6])
							4'd2:    w[6:5] = 2'd0;
							4'd3:    w[6:5] = 2'd1;
							4'd4:    w[6:5] = 2'd2;
							default: w[6:5] = 2'd3;
						endcase
					end
					4'd8: begin
						w[24:21] = OP_TST;
						w[18:16] = r0;
						w[2:0]   = r1;
					end
					4'd9: begin
						// NEG as RSB #0
						w[25]    = 1'b1;
						w[24:21] = OP_RSB;
						w[18:16] = r1;
						w[14:12] = r0;
					end
					4'd13: begin
						// MULS
						w[18:16] = r0;
						w[10:8]  = r0;
						w[7:4]   = 4'b1001;
						w[2:0]   = r1;
						cl       = CL_MUL;
					end
					4'd15: begin
						w[24:21] = OP_MVN;
						w[14:12] = r0;
						w[2:0]   = r1;
					end
					default: begin
						w  = '0;
						cl = CL_NONE;
					end
				endcase
			end
			6'b010001: begin
				// hi-register group, BX folds into MOV
				w[31:28] = COND_AL;
				w[20]    = 1'b1;
				w[3:0]   = hm;
				cl       = CL_DP;
				unique case (thumb_word[9:8])
					2'd0: begin
						w[24:21] = OP_ADD;
						w[19:16] = hd;
						w[15:12] = hd;
					end
					2'd1: begin
						w[24:21] = OP_CMP;
						w[19:16] = hd;
					end
					default: begin
						w[24:21] = OP_MOV;
						w[15:12] = hd;
					end
				endcase
			end
			6'b01001?: begin
				// PC-relative load
				w[31:28] = COND_AL;
				w[26]    = 1'b1;
				w[24:23] = 2'b11;
				w[20]    = 1'b1;
				w[19:16] = REG_PC;
				w[14:12] = r8;
				w[9:2]   = im8;
				cl       = CL_SDT;
			end
			6'b0101??: begin
				w[31:28] = COND_AL;
				w[26:23] = 4'b1111;
				w[22]    = thumb_word[10];
				w[20]    = thumb_word[11];
				w[18:16] = r1;
				w[14:12] = r0;
				w[2:0]   = r2;
				cl       = CL_SDT;
			end
			6'b011???: begin
				w[31:28] = COND_AL;
				w[26]    = 1'b1;
				w[24:23] = 2'b11;
				w[22]    = thumb_word[12];
				w[20]    = thumb_word[11];
				w[18:16] = r1;
				w[14:12] = r0;
				w[6:2]   = im5;
				cl       = CL_SDT;
			end
			6'b1001??: begin
				// SP-relative, load when bit 11 clear
				w[31:28] = COND_AL;
				w[26]    = 1'b1;
				w[24:23] = 2'b11;
				w[20]    = ~thumb_word[11];
				w[19:16] = REG_SP;
				w[14:12] = r8;
				w[9:2]   = im8;
				cl       = CL_SDT;
			end
			6'b1010??: begin
				w[31:28] = COND_AL;
				w[25]    = 1'b1;
				w[24:21] = OP_ADD;
				w[19:16] = thumb_word[11] ? REG_SP : REG_PC;
				w[14:12] = r8;
				w[7:0]   = im8;
				cl       = CL_DPIMM;
			end
			6'b1011?0: begin
				// SP adjust
				w[31:28] = COND_AL;
				w[25]    = 1'b1;
				w[24:21] = thumb_word[7] ? OP_SUB : OP_ADD;
				w[19:16] = REG_SP;
				w[15:12] = REG_SP;
				w[11:8]  = REG_PC;
				w[6:0]   = thumb_word[6:0];
				cl       = CL_DPIMM;
			end
			6'b101101: begin
				// push
				w[31:28] = COND_AL;
				w[27]    = 1'b1;
				w[24]    = 1'b1;
				w[21]    = 1'b1;
				w[19:16] = REG_SP;
				w[14]    = thumb_word[8];
				w[7:0]   = im8;
				cl       = CL_BDT;
			end
			6'b101111: begin
				// pop
				w[31:28] = COND_AL;
				w[27]    = 1'b1;
				w[23]    = 1'b1;
				w[21:20] = 2'b11;
				w[19:16] = REG_SP;
				w[15]    = thumb_word[8];
				w[7:0]   = im8;
				cl       = CL_BDT;
			end
			6'b1100??: begin
				w[31:28] = COND_AL;
				w[27]    = 1'b1;
				w[23]    = 1'b1;
				w[21]    = 1'b1;
				w[20]    = thumb_word[11];
				w[18:16] = r8;
				w[7:0]   = im8;
				cl       = CL_BDT;
			end
			6'b1101??: begin
				w[31:28] = thumb_word[11:8];
				w[23:16] = im8;
				cl       = CL_BRA;
			end
			6'b11100?: begin
				w[31:28] = COND_AL;
				w[23:16] = im8;
				cl       = CL_BRA;
			end
			6'b11101?: begin
				cl = CL_UND;
			end
			6'b1111??: begin
				w[15:0] = thumb_word;
				cl      = CL_LONG;
			end
			default: begin
				w  = '0;
				cl = CL_NONE;
			end
		endcase
	end

	assign result.arm_word      = w;
	assign result.handler_class = cl;

endmodule

// File: sv/thumb_to_arm_decompressor.sv
// Thumb-to-ARM decompressor. Each transaction is one 16-bit Thumb instruction on
// thumb_word, taken at a clock edge with start high (busy is always low, so every
// start is taken). The instruction is registered in stage 1 and decoded into the
// stage-2 result register, whose ARM word and handler class appear on arm_word /
// handler_class with done high for exactly one cycle, and they are taken at the edge
// that ends that cycle. The receiver cannot stall, so it must capture them then.
// Throughput is one instruction per clock: an input register, one level of decode
// logic, and a result register form a fixed two-stage pipe with nothing that ever
// holds it back. Long-branch halves pass the Thumb word through zero-extended;
// unhandled encodings give class none with a zero word.
`include "thumb_to_arm_decompressor_defines.svh"

module thumb_to_arm_decompressor import t2a_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] thumb_word,
	output logic        done,
	output logic [31:0] arm_word,
	output logic [3:0]  handler_class
);

	logic        valid_s1;
	logic [15:0] thumb_s1;
	logic        valid_s2;
	t2a_result_t result_s2;
	t2a_result_t dec_result;

	// pipe never stalls
	assign busy = 1'b0;

	// stage 1: capture the instruction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			thumb_s1 <= thumb_word;
		end
	end

	t2a_decode u_decode (
		.thumb_word (thumb_s1),
		.result     (dec_result)
	);

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= dec_result;
		end
	end

	assign done          = valid_s2;
	assign arm_word      = result_s2.arm_word;
	assign handler_class = result_s2.handler_class;

	`T2A_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, start && !busy, valid_s1)
	`T2A_ASSERT_NEXT(a_s1_to_done, clk, arst_n, valid_s1, done)
	`T2A_ASSERT_NEXT(a_no_spurious_done, clk, arst_n, !valid_s1, !done)
	`T2A_ASSERT_IMPL(a_class_range, clk, arst_n, done, handler_class <= CL_NONE)
	`T2A_ASSERT_IMPL(a_long_passthru, clk, arst_n, done && handler_class == CL_LONG, arm_word[31:12] == 20'h0000F)

endmodule

// File: tb/sv/thumb_to_arm_decompressor_checker.sv
module thumb_to_arm_decompressor_checker import t2a_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] thumb_word,
	input  logic        done,
	input  logic [31:0] arm_word,
	input  logic [3:0]  handler_class,
	output int          fail_count,
	output int          pending
);

	localparam logic [31:0] S_BIT = 32'h0010_0000;
	localparam logic [31:0] I_BIT = 32'h0200_0000;
	localparam logic [31:0] L_BIT = 32'h0010_0000;
	localparam logic [31:0] B_BIT = 32'h0040_0000;
	localparam logic [31:0] AL_BASE = {COND_AL, 28'h0};
	localparam logic [31:0] XFER_BASE = AL_BASE | 32'h0180_0000 | 32'h0400_0000;
	localparam logic [31:0] BLOCK_BASE = AL_BASE | 32'h0800_0000 | 32'h0020_0000;

	t2a_result_t arm_expect_q[$];
	t2a_result_t oldest;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic logic [31:0] dp_base(input logic [3:0] op);
		return {COND_AL, 3'b000, op, 21'h0};
	endfunction

	// translate one Thumb instruction into ARM word + handler class
	function automatic t2a_result_t decode_thumb(input logic [15:0] t);
		t2a_result_t res;
		logic [31:0] r0, r1, r2, r8, im5, im8, hd, hm, two, rsh, w;
		logic [3:0] cl;
		r0 = 32'(t[2:0]);
		r1 = 32'(t[5:3]);
		r2 = 32'(t[8:6]);
		r8 = 32'(t[10:8]);
		im5 = 32'(t[10:6]);
		im8 = 32'(t[7:0]);
		w = '0;
		cl = CL_NONE;
		case (t[15:10])
			6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: begin
				w = dp_base(OP_MOV) | S_BIT | (r0 << 12) | (im5 << 7)
					| (32'(t[12:11]) << 5) | r1;
				cl = CL_DP;
			end
			6'd6: begin
				w = dp_base(t[9] ? OP_SUB : OP_ADD) | S_BIT | (r1 << 16) | (r0 << 12) | r2;
				cl = CL_DP;
			end
			6'd8, 6'd9: begin
				w = dp_base(OP_CMP) | S_BIT | I_BIT | (r8 << 16) | im8;
				cl = CL_DPIMM;
			end
			6'd10, 6'd11: begin
				w = dp_base(OP_MOV) | S_BIT | I_BIT | (r8 << 12) | im8;
				cl = CL_DPIMM;
			end
			6'd12, 6'd13, 6'd14, 6'd15: begin
				w = dp_base(t[11] ? OP_SUB : OP_ADD) | S_BIT | I_BIT
					| (r8 << 16) | (r8 << 12) | im8;
				cl = CL_DPIMM;
			end
			6'd16: begin
				two = (r0 << 16) | (r0 << 12) | r1 | S_BIT;
				rsh = (r0 << 16) | (r0 << 12) | 32'h10 | (r1 << 8) | S_BIT;
				cl = CL_DP;
				case (t[9:6])
					4'd0: w = dp_base(OP_AND) | two;
					4'd1: w = dp_base(OP_EOR) | two;
					4'd2: w = dp_base(OP_MOV) | rsh;
					4'd3: w = dp_base(OP_MOV) | rsh | (32'd1 << 5);
					4'd4: w = dp_base(OP_MOV) | rsh | (32'd2 << 5);
					4'd5: w = dp_base(OP_ADC) | two;
					4'd6: w = dp_base(OP_SBC) | two;
					4'd7: w = dp_base(OP_MOV) | rsh | (32'd3 << 5);
					4'd8: w = dp_base(OP_TST) | S_BIT | (r0 << 16) | r1;
					4'd9: w = dp_base(OP_RSB) | S_BIT | I_BIT | (r1 << 16) | (r0 << 12);
					4'd12: w = dp_base(OP_ORR) | two;
					4'd13: begin
						w = AL_BASE | S_BIT | (r0 << 16) | (r0 << 8) | 32'h90 | r1;
						cl = CL_MUL;
					end
					4'd14: w = dp_base(OP_BIC) | two;
					4'd15: w = dp_base(OP_MVN) | S_BIT | (r0 << 12) | r1;
					default: begin
						w = '0;
						cl = CL_NONE;
					end
				endcase
			end
			6'd17: begin
				hd = 32'({t[7], 1'b0, t[1:0]});
				hm = 32'({t[6], 1'b0, t[4:3]});
				case (t[9:8])
					2'd0: w = dp_base(OP_ADD) | S_BIT | (hd << 16) | (hd << 12) | hm;
					2'd1: w = dp_base(OP_CMP) | S_BIT | (hd << 16) | hm;
					default: w = dp_base(OP_MOV) | S_BIT | (hd << 12) | hm;
				endcase
				cl = CL_DP;
			end
			6'd18, 6'd19: begin
				w = XFER_BASE | L_BIT | (32'(REG_PC) << 16) | (r8 << 12) | (im8 << 2);
				cl = CL_SDT;
			end
			6'd20, 6'd21, 6'd22, 6'd23: begin
				w = XFER_BASE | I_BIT | (r1 << 16) | (r0 << 12) | r2
					| (t[11] ? L_BIT : '0) | (t[10] ? B_BIT : '0);
				cl = CL_SDT;
			end
			6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31: begin
				w = XFER_BASE | (r1 << 16) | (r0 << 12) | (im5 << 2)
					| (t[11] ? L_BIT : '0) | (t[12] ? B_BIT : '0);
				cl = CL_SDT;
			end
			6'd36, 6'd37, 6'd38, 6'd39: begin
				w = XFER_BASE | (32'(REG_SP) << 16) | (r8 << 12) | (im8 << 2)
					| (t[11] ? '0 : L_BIT);
				cl = CL_SDT;
			end
			6'd40, 6'd41, 6'd42, 6'd43: begin
				w = dp_base(OP_ADD) | I_BIT | (32'(t[11] ? REG_SP : REG_PC) << 16)
					| (r8 << 12) | im8;
				cl = CL_DPIMM;
			end
			6'd44, 6'd46: begin
				w = dp_base(t[7] ? OP_SUB : OP_ADD) | I_BIT | (32'(REG_SP) << 16)
					| (32'(REG_SP) << 12) | (32'(REG_PC) << 8) | 32'(t[6:0]);
				cl = CL_DPIMM;
			end
			6'd45: begin
				w = BLOCK_BASE | (32'd1 << 24) | (32'(REG_SP) << 16) | im8
					| (t[8] ? (32'd1 << 14) : '0);
				cl = CL_BDT;
			end
			6'd47: begin
				w = BLOCK_BASE | (32'd1 << 23) | L_BIT | (32'(REG_SP) << 16) | im8
					| (t[8] ? (32'd1 << 15) : '0);
				cl = CL_BDT;
			end
			6'd48, 6'd49, 6'd50, 6'd51: begin
				w = BLOCK_BASE | (32'd1 << 23) | (r8 << 16) | im8 | (t[11] ? L_BIT : '0);
				cl = CL_BDT;
			end
			6'd52, 6'd53, 6'd54, 6'd55: begin
				w = {t[11:8], 28'h0} | (im8 << 16);
				cl = CL_BRA;
			end
			6'd56, 6'd57: begin
				w = AL_BASE | (im8 << 16);
				cl = CL_BRA;
			end
			6'd58, 6'd59: begin
				w = '0;
				cl = CL_UND;
			end
			6'd60, 6'd61, 6'd62, 6'd63: begin
				w = {16'h0, t};
				cl = CL_LONG;
			end
			default: begin
				w = '0;
				cl = CL_NONE;
			end
		endcase
		res.arm_word = w;
		res.handler_class = cl;
		return res;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_expect_q.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (arm_expect_q.size() == 0) begin
					report_error($sformatf("unexpected result arm_word=%h class=%0d",
						arm_word, handler_class));
				end else begin
					oldest = arm_expect_q.pop_front();
					if (arm_word !== oldest.arm_word)
						report_error($sformatf("arm_word %h, expected %h (class %0d)",
							arm_word, oldest.arm_word, oldest.handler_class));
					if (handler_class !== oldest.handler_class)
						report_error($sformatf("handler_class %0d, expected %0d (word %h)",
							handler_class, oldest.handler_class, oldest.arm_word));
				end
			end
			if (start && !busy)
				arm_expect_q.push_back(decode_thumb(thumb_word));
			pending <= arm_expect_q.size();
		end
	end

endmodule

// File: tb/sv/thumb_to_arm_decompressor_test.sv
// Stimulus and verdict for the Thumb-to-ARM decompressor. The checker beside the
// DUT predicts every transaction and compares; this module only feeds
// instructions, paces them, and reports the outcome.
module thumb_to_arm_decompressor_test;
	import t2a_pkg::*;

	localparam int RANDOM_ITEMS = 950;
	localparam int DRAIN_CYCLES = 8;     // pipe is two deep; a few extra for margin
	localparam int IDLE_LIMIT   = 2000;  // well past the longest sender gap

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [15:0] thumb_word = '0;
	logic        busy;
	logic        done;
	logic [31:0] arm_word;
	logic [3:0]  handler_class;

	int fail_count;
	int pending;
	int idle_cycles = 0;
	int burst_left = 0;

	always #2 clk = ~clk;

	thumb_to_arm_decompressor dut (.*);

	thumb_to_arm_decompressor_checker checker_i (.*);

	// Watchdog: any cycle with neither an accepted instruction nor a result
	// counts toward the limit; a stuck pipe ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Present one instruction and hold it until the edge that takes it.
	// start stays high on return so back-to-back transactions need no toggle.
	task automatic issue_word(input logic [15:0] w);
		start <= 1'b1;
		thumb_word <= w;
		do @(posedge clk); while (busy);
	endtask

	// Drop start for the idle gap given by n; the data bus carries noise meanwhile.
	task automatic idle_for(input int n);
		if (n > 0) begin
			start <= 1'b0;
			thumb_word <= 16'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	// Mostly short gaps, a few long ones; bursts force stretches with none.
	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Weight the ALU and hi-register groups, since their sub-selectors are
	// where most of the opcode mapping lives; the rest is fully random.
	function automatic logic [15:0] random_word();
		case ($urandom_range(0, 3))
			0: return {6'b010000, 10'($urandom)};
			1: return {6'b010001, 10'($urandom)};
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] directed_q[$];
		logic [3:0] sel;
		logic [1:0] hsel;

		// every ALU selector, including the two unhandled ones
		for (int i = 0; i < 16; i++) begin
			sel = 4'(i);
			directed_q.push_back({6'b010000, sel, 6'($urandom)});
		end
		// hi-register selectors, BX included; flag pairs cover all four mixes
		for (int i = 0; i < 4; i++) begin
			hsel = 2'(i);
			directed_q.push_back({6'b010001, hsel, hsel[0], hsel[1] ^ hsel[0],
				6'($urandom)});
		end
		directed_q.push_back(16'h0000);  // all-zero: LSL #0
		directed_q.push_back(16'hFFFF);  // all-ones: long-branch half
		directed_q.push_back(16'h1FFF);  // add/sub with 3-bit immediate: none
		directed_q.push_back(16'h8000);  // halfword immediate store: none
		directed_q.push_back(16'hE800);  // undefined space
		directed_q.push_back(16'hDEFF);  // conditional branch, condition AL
		directed_q.push_back(16'hDF80);  // conditional branch, condition NV
		directed_q.push_back(16'hB0FF);  // SP adjust, subtract, full offset

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i]) begin
			issue_word(directed_q[i]);
			idle_for(next_gap());
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 200 == 0)
				burst_left = 40;
			issue_word(random_word());
			idle_for(next_gap());
		end
		start <= 1'b0;

		// drain: wait out the queue, then let the pipe settle
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
